// ===== hw/rtl/tsp_pkg.sv =====
// Shared types and constants of the TCP timestamp option parser.
`default_nettype none
package tsp_pkg;

  // Parse phases
  localparam logic [2:0] PH_KIND = 3'd0;
  localparam logic [2:0] PH_LEN  = 3'd1;
  localparam logic [2:0] PH_SKIP = 3'd2;
  localparam logic [2:0] PH_TS   = 3'd3;
  localparam logic [2:0] PH_DONE = 3'd4;

  // Result status codes
  localparam logic [2:0] ST_FOUND  = 3'd0;
  localparam logic [2:0] ST_EOL    = 3'd1;
  localparam logic [2:0] ST_BADLEN = 3'd2;
  localparam logic [2:0] ST_TRUNC  = 3'd3;
  localparam logic [2:0] ST_LIMIT  = 3'd4;
  localparam logic [2:0] ST_NONE   = 3'd5;

  // Option kinds and lengths
  localparam logic [7:0] KIND_EOL = 8'd0;
  localparam logic [7:0] KIND_NOP = 8'd1;
  localparam logic [7:0] KIND_TS  = 8'd8;
  localparam logic [7:0] LEN_TS   = 8'd10;
  localparam logic [7:0] LEN_MIN  = 8'd2;
  localparam logic [3:0] TS_BYTES = 4'd8;

  localparam logic [5:0] LIMIT_RESET = 6'd10;

  typedef struct packed {
    logic [7:0] opt_byte;
    logic       first_byte;
    logic       last_byte;
    logic       no_options;
  } item_t;

  typedef struct packed {
    logic        found;
    logic [2:0]  status;
    logic [31:0] ts_value;
    logic [31:0] ts_echo_reply;
  } result_t;

endpackage
`default_nettype wire

// ===== hw/rtl/tsp_in_if.sv =====
// Option byte request channel.
`default_nettype none
interface tsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] opt_byte;
  logic       first_byte;
  logic       last_byte;
  logic       no_options;

  modport source (output valid, opt_byte, first_byte, last_byte, no_options, input ready);
  modport sink   (input valid, opt_byte, first_byte, last_byte, no_options, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/tsp_out_if.sv =====
// Parse result request channel.
`default_nettype none
interface tsp_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [2:0]  status;
  logic [31:0] ts_value;
  logic [31:0] ts_echo_reply;

  modport source (output valid, found, status, ts_value, ts_echo_reply, input ready);
  modport sink   (input valid, found, status, ts_value, ts_echo_reply, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/tsp_cfg_if.sv =====
// Option limit register write channel.
`default_nettype none
interface tsp_cfg_if;
  logic       valid;
  logic       ready;
  logic [5:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/tsp_in_stage.sv =====
// Input register stage for option byte requests.
`default_nettype none
module tsp_in_stage (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  tsp_in_if.sink             in_i,
  input  wire logic          take_i,
  output tsp_pkg::item_t     item_o,
  output logic               valid_o
);

  logic           valid_q;
  tsp_pkg::item_t item_q;

  // Free when empty or when the held request moves on this cycle
  assign in_i.ready = !valid_q || take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      item_q <= '{opt_byte:   in_i.opt_byte,
                  first_byte: in_i.first_byte,
                  last_byte:  in_i.last_byte,
                  no_options: in_i.no_options};
    end
  end

  assign item_o  = item_q;
  assign valid_o = valid_q;

endmodule
`default_nettype wire

// ===== hw/rtl/tsp_parse_core.sv =====
// Option walk state and per-byte next-state and result logic.
`default_nettype none
module tsp_parse_core (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             take_i,
  input  wire tsp_pkg::item_t   item_i,
  input  wire logic [5:0]       limit_i,
  output logic                  res_valid_o,
  output tsp_pkg::result_t      res_o
);

  logic [2:0]  phase_q, phase_d;
  logic [5:0]  seen_q, seen_d;
  logic [7:0]  skip_q, skip_d;
  logic        kind_ts_q, kind_ts_d;
  logic [63:0] tsh_q, tsh_d;
  logic [3:0]  tcnt_q, tcnt_d;

  // Byte step
  always_comb begin
    logic [2:0] st;
    logic       open;
    logic [5:0] seen_inc;
    logic [3:0] tcnt_inc;
    logic [7:0] b;

    b        = item_i.opt_byte;
    st       = tsp_pkg::ST_NONE;
    open     = 1'b1;
    phase_d  = phase_q;
    seen_d   = seen_q;
    skip_d   = skip_q;
    kind_ts_d = kind_ts_q;
    tsh_d    = tsh_q;
    tcnt_d   = tcnt_q;

    // A first mark restarts the walk
    if (item_i.first_byte) begin
      phase_d   = tsp_pkg::PH_KIND;
      seen_d    = '0;
      skip_d    = '0;
      kind_ts_d = 1'b0;
      tsh_d     = '0;
      tcnt_d    = '0;
    end

    seen_inc = seen_d + 6'd1;
    tcnt_inc = tcnt_d + 4'd1;

    unique case (phase_d)
      tsp_pkg::PH_KIND: begin
        if (seen_d >= limit_i) begin
          st = tsp_pkg::ST_LIMIT; open = 1'b0;
        end else if (b == tsp_pkg::KIND_EOL) begin
          st = tsp_pkg::ST_EOL; open = 1'b0;
        end else if (b == tsp_pkg::KIND_NOP) begin
          seen_d = seen_inc;
          if (seen_inc >= limit_i) begin
            st = tsp_pkg::ST_LIMIT; open = 1'b0;
          end
        end else begin
          kind_ts_d = (b == tsp_pkg::KIND_TS);
          phase_d   = tsp_pkg::PH_LEN;
        end
      end
      tsp_pkg::PH_LEN: begin
        if (b < tsp_pkg::LEN_MIN) begin
          st = tsp_pkg::ST_BADLEN; open = 1'b0;
        end else if (kind_ts_d && b == tsp_pkg::LEN_TS) begin
          tsh_d   = '0;
          tcnt_d  = '0;
          phase_d = tsp_pkg::PH_TS;
        end else begin
          skip_d = b - tsp_pkg::LEN_MIN;
          if (skip_d == 8'd0) begin
            seen_d  = seen_inc;
            phase_d = tsp_pkg::PH_KIND;
            if (seen_inc >= limit_i) begin
              st = tsp_pkg::ST_LIMIT; open = 1'b0;
            end
          end else begin
            phase_d = tsp_pkg::PH_SKIP;
          end
        end
      end
      tsp_pkg::PH_SKIP: begin
        skip_d = skip_d - 8'd1;
        if (skip_d == 8'd0) begin
          seen_d  = seen_inc;
          phase_d = tsp_pkg::PH_KIND;
          if (seen_inc >= limit_i) begin
            st = tsp_pkg::ST_LIMIT; open = 1'b0;
          end
        end
      end
      tsp_pkg::PH_TS: begin
        tsh_d  = {tsh_d[55:0], b};
        tcnt_d = tcnt_inc;
        if (tcnt_inc >= tsp_pkg::TS_BYTES) begin
          st = tsp_pkg::ST_FOUND; open = 1'b0;
        end
      end
      default: begin
        // Outcome already given: drop the byte
        open = 1'b0;
        st   = tsp_pkg::ST_NONE;
      end
    endcase

    // Region ends with the walk still open
    if (phase_d != tsp_pkg::PH_DONE || phase_q != tsp_pkg::PH_DONE || item_i.first_byte) begin
      if (open && item_i.last_byte) begin
        st   = (phase_d == tsp_pkg::PH_KIND) ? tsp_pkg::ST_NONE : tsp_pkg::ST_TRUNC;
        open = 1'b0;
      end
    end

    res_valid_o = 1'b0;
    if (item_i.no_options) begin
      res_valid_o = take_i;
      st          = tsp_pkg::ST_NONE;
    end else if (!open && !(phase_q == tsp_pkg::PH_DONE && !item_i.first_byte)) begin
      res_valid_o = take_i;
      phase_d     = tsp_pkg::PH_DONE;
    end

    res_o.found         = (st == tsp_pkg::ST_FOUND);
    res_o.status        = st;
    res_o.ts_value      = (st == tsp_pkg::ST_FOUND) ? tsh_d[63:32] : 32'd0;
    res_o.ts_echo_reply = (st == tsp_pkg::ST_FOUND) ? tsh_d[31:0]  : 32'd0;

    // Segment closes
    if (item_i.no_options || item_i.last_byte) begin
      phase_d   = tsp_pkg::PH_KIND;
      seen_d    = '0;
      skip_d    = '0;
      kind_ts_d = 1'b0;
      tsh_d     = '0;
      tcnt_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= tsp_pkg::PH_KIND;
      seen_q    <= '0;
      skip_q    <= '0;
      kind_ts_q <= 1'b0;
      tsh_q     <= '0;
      tcnt_q    <= '0;
    end else if (take_i) begin
      phase_q   <= phase_d;
      seen_q    <= seen_d;
      skip_q    <= skip_d;
      kind_ts_q <= kind_ts_d;
      tsh_q     <= tsh_d;
      tcnt_q    <= tcnt_d;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/tsp_out_stage.sv =====
// Result register driving the result channel.
`default_nettype none
module tsp_out_stage (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             res_valid_i,
  input  wire tsp_pkg::result_t res_i,
  output logic                  space_o,
  tsp_out_if.source             out_o
);

  logic             valid_q;
  tsp_pkg::result_t res_q;

  // Room for a new result when empty or draining this cycle
  assign space_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (space_o) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (space_o && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid         = valid_q;
  assign out_o.found         = res_q.found;
  assign out_o.status        = res_q.status;
  assign out_o.ts_value      = res_q.ts_value;
  assign out_o.ts_echo_reply = res_q.ts_echo_reply;

endmodule
`default_nettype wire

// ===== hw/rtl/tcp_timestamp_option_parser.sv =====
// Top level: TCP timestamp option parser, one option byte per request.
// A result is registered at the edge that takes its deciding byte from the input register.
// One byte per cycle unless stalled; input register, one step of parse logic, result register.
// A stalled result register holds the byte stage; bytes without a result still wait for room.
// Reset clears the walk state, both stage valids and sets the option limit to 10.
`default_nettype none
module tcp_timestamp_option_parser (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  tsp_in_if.sink    in_i,
  tsp_cfg_if.sink   cfg_i,
  tsp_out_if.source out_o
);

  logic [5:0]       limit_q;
  logic             s1_valid;
  tsp_pkg::item_t   s1_item;
  logic             space;
  logic             take;
  logic             res_valid;
  tsp_pkg::result_t res;

  // Option limit register
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= tsp_pkg::LIMIT_RESET;
    end else if (cfg_i.valid) begin
      limit_q <= cfg_i.data;
    end
  end

  assign take = s1_valid && space;

  tsp_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .take_i  (take),
    .item_o  (s1_item),
    .valid_o (s1_valid)
  );

  tsp_parse_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .item_i      (s1_item),
    .limit_i     (limit_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  tsp_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .space_o     (space),
    .out_o       (out_o)
  );

  // Timestamp words are zero unless found
  a_words_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.found |-> out_o.ts_value == 32'd0 && out_o.ts_echo_reply == 32'd0)
    else $error("timestamp words nonzero without found");

  // A held byte with a stalled result blocks new requests
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid && out_o.valid && !out_o.ready |-> !in_i.ready)
    else $error("byte accepted while stage blocked");

  // A result is produced only for a byte that moved on
  a_res_on_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> take)
    else $error("result without byte handoff");

endmodule
`default_nettype wire
